### sv/kcl_pkg.sv
// Shared types, constants and the key map for the keypad code lock.
// No dependencies; used by every module of the block.
package kcl_pkg;

    localparam int SCAN_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int VERD_W   = 2;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SECOND = 8'd1;

    // Configuration reset values ('1' and '2')
    localparam logic [CHAR_W-1:0] CODE_FIRST_RST  = 8'h31;
    localparam logic [CHAR_W-1:0] CODE_SECOND_RST = 8'h32;

    // Verdict codes
    typedef enum logic [VERD_W-1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_OPEN  = 2'd1,
        VERDICT_ALARM = 2'd2
    } verdict_t;

    // Key map indexed by scan bit position
    typedef logic [CHAR_W-1:0] key_map_t [SCAN_W];
    localparam key_map_t KEY_MAP = '{
        8'h2A, 8'h30, 8'h23, 8'h44,   // '*' '0' '#' 'D'
        8'h37, 8'h38, 8'h39, 8'h43,   // '7' '8' '9' 'C'
        8'h34, 8'h35, 8'h36, 8'h42,   // '4' '5' '6' 'B'
        8'h31, 8'h32, 8'h33, 8'h41    // '1' '2' '3' 'A'
    };

    // Decoded key handed from the front end to the lock stage
    typedef struct packed {
        logic              advance;
        logic              key_valid;
        logic [CHAR_W-1:0] key_char;
    } key_info_t;

endpackage

### sv/kcl_front.sv
// Input register, debounce, new-press detection and key priority encode.
// Depends on kcl_pkg.
module kcl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*kcl_pkg::SCAN_W-1:0]  s_tdata,
    input  logic                          take,
    output kcl_pkg::key_info_t            key_info
);

    logic                        in_valid_reg;
    logic [kcl_pkg::SCAN_W-1:0]  early_reg;
    logic [kcl_pkg::SCAN_W-1:0]  late_reg;
    logic [kcl_pkg::SCAN_W-1:0]  last_deb_reg;
    logic [kcl_pkg::SCAN_W-1:0]  debounced;
    logic [kcl_pkg::SCAN_W-1:0]  presses;
    logic [kcl_pkg::CHAR_W-1:0]  key_char;
    logic                        advance;

    // Move the held word on when the result stage can take it
    assign advance  = in_valid_reg && take;
    assign s_tready = !in_valid_reg || take;

    // Hold the incoming snapshots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            early_reg <= s_tdata[kcl_pkg::SCAN_W-1:0];
            late_reg  <= s_tdata[2*kcl_pkg::SCAN_W-1:kcl_pkg::SCAN_W];
        end
    end

    // Store the debounced state as each word leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_deb_reg <= '0;
        end
        else if (advance)
        begin
            last_deb_reg <= debounced;
        end
    end

    assign debounced = early_reg & late_reg;
    assign presses   = debounced & ~last_deb_reg;

    // Lowest set bit wins: scan from the top so lower bits overwrite
    always_comb
    begin
        key_char = '0;
        for (int i = kcl_pkg::SCAN_W - 1; i >= 0; i--)
        begin
            if (presses[i])
            begin
                key_char = kcl_pkg::KEY_MAP[i];
            end
        end
    end

    assign key_info.advance   = advance;
    assign key_info.key_valid = |presses;
    assign key_info.key_char  = key_char;

endmodule

### sv/kcl_lock.sv
// Code registers, two-key pair tracking, verdict and the result register.
// Depends on kcl_pkg.
module kcl_lock (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcl_pkg::CHAR_W-1:0]      cfg_data,
    input  kcl_pkg::key_info_t              key_info,
    output logic                            take,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            key_valid,
    output logic [kcl_pkg::CHAR_W-1:0]      key_char,
    output kcl_pkg::verdict_t               verdict
);

    logic [kcl_pkg::CHAR_W-1:0]  code_first_reg;
    logic [kcl_pkg::CHAR_W-1:0]  code_second_reg;
    logic                        have_first_reg;
    logic                        have_first_next;
    logic [kcl_pkg::CHAR_W-1:0]  held_first_reg;
    logic [kcl_pkg::CHAR_W-1:0]  held_first_next;
    logic                        out_valid_reg;
    logic                        key_valid_reg;
    logic [kcl_pkg::CHAR_W-1:0]  key_char_reg;
    kcl_pkg::verdict_t           verdict_reg;
    kcl_pkg::verdict_t           verdict_next;

    // Result register frees up when empty or being drained
    assign take = !out_valid_reg || out_ready;

    // Write the code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_first_reg  <= kcl_pkg::CODE_FIRST_RST;
            code_second_reg <= kcl_pkg::CODE_SECOND_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kcl_pkg::REG_CODE_FIRST:  code_first_reg  <= cfg_data;
                kcl_pkg::REG_CODE_SECOND: code_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pair tracking and verdict
    always_comb
    begin
        have_first_next = have_first_reg;
        held_first_next = held_first_reg;
        verdict_next    = kcl_pkg::VERDICT_NONE;
        if (key_info.key_valid)
        begin
            if (!have_first_reg)
            begin
                have_first_next = 1'b1;
                held_first_next = key_info.key_char;
            end
            else
            begin
                have_first_next = 1'b0;
                held_first_next = '0;
                if (held_first_reg == code_first_reg &&
                    key_info.key_char == code_second_reg)
                begin
                    verdict_next = kcl_pkg::VERDICT_OPEN;
                end
                else
                begin
                    verdict_next = kcl_pkg::VERDICT_ALARM;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            held_first_reg <= '0;
        end
        else if (key_info.advance)
        begin
            have_first_reg <= have_first_next;
            held_first_reg <= held_first_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= key_info.advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_info.advance)
        begin
            key_valid_reg <= key_info.key_valid;
            key_char_reg  <= key_info.key_char;
            verdict_reg   <= verdict_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_valid = key_valid_reg;
    assign key_char  = key_char_reg;
    assign verdict   = verdict_reg;

endmodule

### sv/keypad_code_lock.sv
// Keypad code lock: an accepted input word moves from the input register into
// the result register when the result register is free; throughput one word
// per cycle when the output does not stall, set by the single input register and
// result register with one step of logic between them.
// Reset (rst_n, async, active low) clears the input and result valid flags, the
// stored debounced state and the pair state and loads the code registers with '1' and '2'.
// Top level; depends on kcl_pkg, kcl_front and kcl_lock.
module keypad_code_lock (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*kcl_pkg::SCAN_W-1:0]    s_tdata,   // scan_early[15:0], scan_late[31:16]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // key_valid[0], key_char[8:1],
                                                       // verdict[10:9], zero[15:11]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcl_pkg::CHAR_W-1:0]      cfg_data
);

    kcl_pkg::key_info_t          key_info;
    logic                        take;
    logic                        key_valid;
    logic [kcl_pkg::CHAR_W-1:0]  key_char;
    kcl_pkg::verdict_t           verdict;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    kcl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .key_info (key_info)
    );

    kcl_lock u_lock (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_info  (key_info),
        .take      (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .key_valid (key_valid),
        .key_char  (key_char),
        .verdict   (verdict)
    );

    // Pack the result word
    assign m_tdata = {5'b0, verdict, key_char, key_valid};

endmodule

### sv/kcl_checker.sv
// Port-level checks for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock.
module kcl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [15:0]                     m_tdata
);

    // A decision only comes with a detected key
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[10:9] != kcl_pkg::VERDICT_NONE) |-> m_tdata[0])
        else $error("verdict without key");

    // No key means a zero character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[8:1] == 8'd0))
        else $error("character without key");

    // Only defined verdict codes and zero padding
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:9] != 2'd3) && (m_tdata[15:11] == 5'd0))
        else $error("bad result word");

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An empty result side never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result side");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
